// ----- src/psr2d_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psr2d_pkg
// Shared widths, field layout and the job record for the 2D particle refiner.
// -----------------------------------------------------------------------------
package psr2d_pkg;

   // Field widths
   localparam int COORD_W = 32;
   localparam int NORM_W  = 16;
   localparam int SIZE_W  = 32;
   localparam int KIND_W  = 8;
   localparam int LEVEL_W = 8;
   localparam int INDEX_W = 32;

   // Offsets carry one extra bit so that a negated tangent offset still fits.
   localparam int OFF_W = COORD_W + 1;

   // Stream widths
   localparam int REQ_TDATA_W = 3 * COORD_W + 3 * NORM_W + SIZE_W + LEVEL_W;
   localparam int REQ_TUSER_W = 1 + KIND_W;
   localparam int RSP_TDATA_W = INDEX_W + 3 * COORD_W + 3 * NORM_W + SIZE_W + LEVEL_W;
   localparam int RSP_TUSER_W = KIND_W;

   // Default depth of the queue between the front and back halves.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Number of children minus one, as held in a job.
   localparam logic [1:0] LAST_CHILD_COPY     = 2'd0;
   localparam logic [1:0] LAST_CHILD_BOUNDARY = 2'd1;
   localparam logic [1:0] LAST_CHILD_INTERIOR = 2'd3;

   // One classified particle, ready for the back half to expand into children.
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] new_z;
      logic signed [NORM_W-1:0]  norm_x;
      logic signed [NORM_W-1:0]  norm_y;
      logic signed [NORM_W-1:0]  norm_z;
      logic [SIZE_W-1:0]         new_spacing;
      logic [KIND_W-1:0]         kind;
      logic [LEVEL_W-1:0]        level;
      logic signed [OFF_W-1:0]   off_x;
      logic signed [OFF_W-1:0]   off_y;
      logic                      interior;
      logic [1:0]                last_child;
   } job_type;

endpackage

// ----- src/psr2d_front.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psr2d_front
// Accepts particle requests, classifies them and works out the child offsets.
// -----------------------------------------------------------------------------
module psr2d_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, spacing, level
   input  logic [psr2d_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // split, kind
   input  logic [psr2d_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               job_valid,
   input  logic                               job_ready,
   output psr2d_pkg::job_type                 job
);
   import psr2d_pkg::*;

   logic                   hold_valid_ff;
   logic                   hold_valid_in;
   logic [REQ_TDATA_W-1:0] tdata_ff;
   logic [REQ_TUSER_W-1:0] tuser_ff;

   logic                      split;
   logic [KIND_W-1:0]         kind;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic signed [NORM_W-1:0]  norm_x;
   logic signed [NORM_W-1:0]  norm_y;
   logic signed [NORM_W-1:0]  norm_z;
   logic [SIZE_W-1:0]         spacing;
   logic [LEVEL_W-1:0]        level;

   logic signed [SIZE_W+NORM_W:0] prod_dx;
   logic signed [SIZE_W+NORM_W:0] prod_dy;
   logic signed [OFF_W-1:0]       dx;
   logic signed [OFF_W-1:0]       dy;
   logic signed [OFF_W-1:0]       quarter;

   // A request is taken whenever the holding register is empty or moves on.
   assign req_tready = !hold_valid_ff || job_ready;
   assign job_valid  = hold_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_tready) begin
         hold_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (req_tready && req_tvalid) begin
         tdata_ff <= req_tdata;
         tuser_ff <= req_tuser;
      end
   end

   // Unpack the held request.
   assign split   = tuser_ff[0];
   assign kind    = tuser_ff[KIND_W:1];
   assign pos_x   = tdata_ff[COORD_W-1:0];
   assign pos_y   = tdata_ff[2*COORD_W-1:COORD_W];
   assign pos_z   = tdata_ff[3*COORD_W-1:2*COORD_W];
   assign norm_x  = tdata_ff[3*COORD_W+NORM_W-1:3*COORD_W];
   assign norm_y  = tdata_ff[3*COORD_W+2*NORM_W-1:3*COORD_W+NORM_W];
   assign norm_z  = tdata_ff[3*COORD_W+3*NORM_W-1:3*COORD_W+2*NORM_W];
   assign spacing = tdata_ff[3*COORD_W+3*NORM_W+SIZE_W-1:3*COORD_W+3*NORM_W];
   assign level   = tdata_ff[REQ_TDATA_W-1:3*COORD_W+3*NORM_W+SIZE_W];

   // Tangent offsets: exact size times normal, floored by the arithmetic shift.
   assign prod_dx = $signed({1'b0, spacing}) * norm_y;
   assign prod_dy = $signed({1'b0, spacing}) * norm_x;
   assign dx      = prod_dx[SIZE_W+NORM_W:16];
   assign dy      = prod_dy[SIZE_W+NORM_W:16];
   assign quarter = $signed({3'b000, spacing[SIZE_W-1:2]});

   // Classify: plain copy, four interior children or two boundary children.
   always_comb begin
      job.pos_x  = pos_x;
      job.pos_y  = pos_y;
      job.norm_x = norm_x;
      job.norm_y = norm_y;
      job.norm_z = norm_z;
      job.kind   = kind;
      job.level  = level;
      if (!split) begin
         job.new_z       = pos_z;
         job.new_spacing = spacing;
         job.off_x       = '0;
         job.off_y       = '0;
         job.interior    = 1'b0;
         job.last_child  = LAST_CHILD_COPY;
      end else if (kind == '0) begin
         job.new_z       = '0;
         job.new_spacing = {1'b0, spacing[SIZE_W-1:1]};
         job.off_x       = quarter;
         job.off_y       = quarter;
         job.interior    = 1'b1;
         job.last_child  = LAST_CHILD_INTERIOR;
      end else begin
         job.new_z       = '0;
         job.new_spacing = {1'b0, spacing[SIZE_W-1:1]};
         job.off_x       = dx;
         job.off_y       = -dy;
         job.interior    = 1'b0;
         job.last_child  = LAST_CHILD_BOUNDARY;
      end
   end

endmodule

// ----- src/psr2d_queue.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psr2d_queue
// Small first-in first-out queue of classified jobs between front and back.
// -----------------------------------------------------------------------------
module psr2d_queue #(
   parameter int DEPTH = psr2d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  psr2d_pkg::job_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output psr2d_pkg::job_type pop_data
);
   import psr2d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/psr2d_back.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// psr2d_back
// Expands each job into indexed children, one response per cycle unless stalled.
// -----------------------------------------------------------------------------
module psr2d_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  psr2d_pkg::job_type                 job,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_index, new_x, new_y, new_z, new_nx, new_ny, new_nz, new_spacing, new_level
   output logic [psr2d_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // new_kind
   output logic [psr2d_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                               rsp_tlast
);
   import psr2d_pkg::*;

   localparam int SUM_W = COORD_W + 2;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic [KIND_W-1:0]      rsp_kind_ff;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;
   logic [1:0]             child_ff;
   logic [1:0]             child_in;
   logic [INDEX_W-1:0]     index_ff;
   logic [INDEX_W-1:0]     index_in;

   logic                      load_ok;
   logic                      fire;
   logic                      final_child;
   logic                      neg_x;
   logic                      neg_y;
   logic signed [SUM_W-1:0]   off_x;
   logic signed [SUM_W-1:0]   off_y;
   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;
   logic signed [COORD_W-1:0] new_x;
   logic signed [COORD_W-1:0] new_y;

   // Clamp a widened coordinate into the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] saturate(
      input logic signed [SUM_W-1:0] value
   );
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (value > hi) begin
         return hi[COORD_W-1:0];
      end else if (value < lo) begin
         return lo[COORD_W-1:0];
      end
      return value[COORD_W-1:0];
   endfunction

   // The output register reloads when empty or when its response is taken.
   assign load_ok     = !rsp_valid_ff || rsp_tready;
   assign fire        = job_valid && load_ok;
   assign final_child = child_ff == job.last_child;
   assign job_ready   = load_ok && final_child;

   // Offset signs per child: interior children walk (-,-) (-,+) (+,-) (+,+),
   // boundary children take the minus side first.
   assign neg_x = job.interior ? !child_ff[1] : !child_ff[0];
   assign neg_y = !child_ff[0];
   assign off_x = neg_x ? -SUM_W'(job.off_x) : SUM_W'(job.off_x);
   assign off_y = neg_y ? -SUM_W'(job.off_y) : SUM_W'(job.off_y);
   assign sum_x = SUM_W'(job.pos_x) + off_x;
   assign sum_y = SUM_W'(job.pos_y) + off_y;
   assign new_x = saturate(sum_x);
   assign new_y = saturate(sum_y);

   // Next response, child counter and running index.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      child_in     = child_ff;
      index_in     = index_ff;
      if (load_ok) begin
         rsp_valid_in = job_valid;
      end
      if (fire) begin
         rsp_data_in = {job.level, job.new_spacing, job.norm_z, job.norm_y, job.norm_x,
                        job.new_z, new_y, new_x, index_ff};
         rsp_last_in = final_child;
         child_in    = final_child ? 2'd0 : child_ff + 2'd1;
         index_in    = index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         child_ff     <= '0;
         index_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         child_ff     <= child_in;
         index_ff     <= index_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (fire) begin
         rsp_kind_ff <= job.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/particle_split_refiner_2d_core.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// particle_split_refiner_2d_core
// Refines 2D particles into their children, streaming one response per child.
// -----------------------------------------------------------------------------
// Each request is one particle; it yields one response when not split, four
// when split as an interior particle (kind zero) and two when split on the
// boundary, the last of them marked by rsp_tlast. Responses leave at one per
// cycle from the single output register unless rsp_tready stalls them; a
// request passes the front holding register, the queue and the output
// register before its first response appears. The front half registers
// and classifies the request and forms the tangent offsets with two 33x16
// multipliers, and a short queue lets new requests arrive while the back
// half is still emitting the previous children. The out_index field counts
// every response since reset and wraps at 2^32.
// -----------------------------------------------------------------------------
module particle_split_refiner_2d_core #(
   parameter int QUEUE_DEPTH = psr2d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, spacing, level
   input  logic [psr2d_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // split, kind
   input  logic [psr2d_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_index, new_x, new_y, new_z, new_nx, new_ny, new_nz, new_spacing, new_level
   output logic [psr2d_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // new_kind
   output logic [psr2d_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   output logic                               rsp_tlast
);
   import psr2d_pkg::*;

   logic    front_valid;
   logic    front_ready;
   job_type front_job;
   logic    back_valid;
   logic    back_ready;
   job_type back_job;

   // Request side: classification and offsets.
   psr2d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   // Decoupling queue.
   psr2d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   // Response side: child expansion.
   psr2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job        (back_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sim/particle_split_refiner_2d_core_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// particle_split_refiner_2d_core_tb
// Self-checking bench for the 2D particle split refiner.
// -----------------------------------------------------------------------------
// Particles are sent on the request stream and each one is expanded here into
// the children the block should return: one copy when not split, four around
// an interior particle, two along the tangent of a boundary particle. Every
// response is compared field by field with the oldest child still outstanding.
// Directed particles cover the field extremes, saturation and rounding of the
// tangent offsets; random traffic follows, with bursts of idling on both
// sides, a pause until the block has drained, and a final stretch at full rate.
// -----------------------------------------------------------------------------
module particle_split_refiner_2d_core_tb;
   import psr2d_pkg::*;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [15:0] NORM_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] NORM_MIN  = 16'sh8000;
   localparam logic [31:0]        SIZE_MAX  = 32'hFFFF_FFFF;
   localparam logic [7:0]         KIND_INTERIOR = 8'd0;
   localparam int                 DRAIN_CYCLES  = 16;

   // One particle as it is sent.
   typedef struct {
      logic                      split;
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [NORM_W-1:0]  norm_x;
      logic signed [NORM_W-1:0]  norm_y;
      logic signed [NORM_W-1:0]  norm_z;
      logic [SIZE_W-1:0]         spacing;
      logic [LEVEL_W-1:0]        level;
   } particle_type;

   // One child as it should come back.
   typedef struct {
      logic [INDEX_W-1:0]        out_index;
      logic signed [COORD_W-1:0] new_x;
      logic signed [COORD_W-1:0] new_y;
      logic signed [COORD_W-1:0] new_z;
      logic signed [NORM_W-1:0]  new_nx;
      logic signed [NORM_W-1:0]  new_ny;
      logic signed [NORM_W-1:0]  new_nz;
      logic [SIZE_W-1:0]         new_spacing;
      logic [KIND_W-1:0]         new_kind;
      logic [LEVEL_W-1:0]        new_level;
      logic                      last;
   } child_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, spacing, level
   logic [REQ_TDATA_W-1:0] req_tdata;
   // split, kind
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // out_index, new_x, new_y, new_z, new_nx, new_ny, new_nz, new_spacing, new_level
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // new_kind
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   child_type          pending_children[$];
   logic [INDEX_W-1:0] next_out_index;
   int                 fail_count;
   bit                 req_gaps_on;
   bit                 rsp_stalls_on;

   particle_split_refiner_2d_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 50 MHz clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("particle_split_refiner_2d_core_tb: FAIL");
      $finish;
   end

   // Clamp a wide coordinate to the signed 32-bit range.
   function automatic logic signed [31:0] clamp_coord(longint v);
      if (v > longint'(COORD_MAX))
         return COORD_MAX;
      if (v < longint'(COORD_MIN))
         return COORD_MIN;
      return v[31:0];
   endfunction

   // Queue one expected child and advance the running index.
   function automatic void push_child(particle_type p, longint cx, longint cy,
                                      logic signed [31:0] cz, logic [31:0] csize,
                                      logic is_last);
      child_type c;
      c.out_index   = next_out_index;
      c.new_x       = clamp_coord(cx);
      c.new_y       = clamp_coord(cy);
      c.new_z       = cz;
      c.new_nx      = p.norm_x;
      c.new_ny      = p.norm_y;
      c.new_nz      = p.norm_z;
      c.new_spacing = csize;
      c.new_kind    = p.kind;
      c.new_level   = p.level;
      c.last        = is_last;
      pending_children.insert(pending_children.size(), c);
      next_out_index = next_out_index + 1;
   endfunction

   // Work out the children of one accepted particle.
   function automatic void expand_particle(particle_type p);
      longint xl;
      longint yl;
      longint size_l;
      longint ny_l;
      longint nx_l;
      longint quarter;
      longint dx;
      longint dy;
      int     a;
      int     b;
      xl     = p.pos_x;
      yl     = p.pos_y;
      size_l = p.spacing;
      nx_l   = p.norm_x;
      ny_l   = p.norm_y;
      if (!p.split) begin
         push_child(p, xl, yl, p.pos_z, p.spacing, 1'b1);
      end else if (p.kind == KIND_INTERIOR) begin
         // Four children on a square, x outer, y inner, minus before plus.
         quarter = size_l >> 2;
         for (a = 0; a < 2; a++) begin
            for (b = 0; b < 2; b++) begin
               push_child(p, a ? xl + quarter : xl - quarter,
                          b ? yl + quarter : yl - quarter, '0, p.spacing >> 1,
                          (a == 1) && (b == 1));
            end
         end
      end else begin
         // Two children along the tangent; offsets are floored products.
         dx = (size_l * ny_l) >>> 16;
         dy = (size_l * nx_l) >>> 16;
         push_child(p, xl - dx, yl + dy, '0, p.spacing >> 1, 1'b0);
         push_child(p, xl + dx, yl - dy, '0, p.spacing >> 1, 1'b1);
      end
   endfunction

   function automatic particle_type make_particle(logic split, logic [7:0] kind,
                                                  logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [15:0] nx,
                                                  logic [15:0] ny, logic [15:0] nz,
                                                  logic [31:0] size, logic [7:0] lvl);
      particle_type p;
      p.split   = split;
      p.kind    = kind;
      p.pos_x   = x;
      p.pos_y   = y;
      p.pos_z   = z;
      p.norm_x  = nx;
      p.norm_y  = ny;
      p.norm_z  = nz;
      p.spacing = size;
      p.level   = lvl;
      return p;
   endfunction

   // Random value of the given width, leaning towards its extremes now and then.
   function automatic logic [31:0] rand_bits(int w);
      logic [63:0] mask;
      logic [63:0] r;
      mask = (64'd1 << w) - 64'd1;
      case ($urandom_range(0, 11))
         0:       r = mask;
         1:       r = '0;
         2:       r = 64'd1 << (w - 1);
         3:       r = mask >> 1;
         4:       r = 64'd1;
         default: r = {32'd0, $urandom};
      endcase
      return r[31:0] & mask[31:0];
   endfunction

   function automatic particle_type rand_particle();
      logic [7:0] kind;
      kind = ($urandom_range(0, 1) == 0) ? KIND_INTERIOR : KIND_W'(rand_bits(KIND_W));
      return make_particle($urandom_range(0, 3) != 0, kind,
                           rand_bits(COORD_W), rand_bits(COORD_W), rand_bits(COORD_W),
                           NORM_W'(rand_bits(NORM_W)), NORM_W'(rand_bits(NORM_W)),
                           NORM_W'(rand_bits(NORM_W)), rand_bits(SIZE_W),
                           LEVEL_W'(rand_bits(LEVEL_W)));
   endfunction

   // Send one particle, with an optional idle burst before it.
   task automatic send_particle(particle_type p);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.level, p.spacing, p.norm_z, p.norm_y, p.norm_x,
                     p.pos_z, p.pos_y, p.pos_x};
      req_tuser  <= {p.kind, p.split};
      do @(posedge clock); while (!req_tready);
      expand_particle(p);
   endtask

   // Stop sending and wait until every outstanding child has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_children.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_unsplit_copy();
      send_particle(make_particle(1'b0, KIND_INTERIOR, '0, '0, '0, '0, '0, '0, '0, '0));
      send_particle(make_particle(1'b0, 8'hFF, COORD_MAX, COORD_MIN, COORD_MAX,
                                  NORM_MAX, NORM_MIN, NORM_MAX, SIZE_MAX, 8'hFF));
      send_particle(make_particle(1'b0, KIND_INTERIOR, COORD_MIN, COORD_MAX, COORD_MIN,
                                  NORM_MIN, NORM_MAX, NORM_MIN, 32'd1, 8'd0));
      send_particle(make_particle(1'b0, 8'd7, 32'h0001_8000, 32'hFFFE_8000, 32'hDEAD_BEEF,
                                  16'h4000, 16'hC000, 16'h1234, 32'h0002_0000, 8'd9));
   endtask

   task automatic test_interior_split();
      send_particle(make_particle(1'b1, KIND_INTERIOR, '0, '0, 32'h1234_5678,
                                  16'h4000, 16'd0, 16'd0, 32'h0004_0000, 8'd3));
      // Sizes below four give a zero quarter and a truncated half.
      send_particle(make_particle(1'b1, KIND_INTERIOR, 32'h0000_1000, 32'hFFFF_F000,
                                  '0, '0, '0, '0, 32'd3, 8'd1));
      // Offsets that run past either end of the coordinate range.
      send_particle(make_particle(1'b1, KIND_INTERIOR, COORD_MAX - 5, COORD_MIN + 5,
                                  COORD_MAX, NORM_MAX, NORM_MIN, NORM_MAX, SIZE_MAX,
                                  8'hFF));
      send_particle(make_particle(1'b1, KIND_INTERIOR, COORD_MIN, COORD_MAX, COORD_MIN,
                                  NORM_MIN, NORM_MAX, NORM_MIN, SIZE_MAX, 8'd0));
      send_particle(make_particle(1'b1, KIND_INTERIOR, 32'hFC18_0000, 32'h0064_0000,
                                  32'h0000_0001, 16'h2D41, 16'hD2BF, 16'h0001,
                                  32'h0001_2345, 8'd200));
   endtask

   task automatic test_boundary_split();
      send_particle(make_particle(1'b1, 8'd1, '0, '0, 32'h0000_5555, 16'd0, 16'h4000,
                                  16'd0, 32'h0001_0000, 8'd2));
      // Largest size against extreme normals, saturating both children.
      send_particle(make_particle(1'b1, 8'hFF, COORD_MAX, COORD_MIN, '0, NORM_MIN,
                                  NORM_MAX, NORM_MIN, SIZE_MAX, 8'hFF));
      send_particle(make_particle(1'b1, 8'h80, COORD_MIN, COORD_MAX, COORD_MAX,
                                  NORM_MAX, NORM_MIN, NORM_MAX, SIZE_MAX, 8'd0));
      // Tiny negative products must round towards minus infinity.
      send_particle(make_particle(1'b1, 8'd2, 32'd100, 32'hFFFF_FF9C, '0, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 32'd1, 8'd4));
      send_particle(make_particle(1'b1, 8'd3, 32'h0010_0000, 32'hFFF0_0000, '0,
                                  16'd5, 16'hFFF9, 16'd0, 32'h0003_0000, 8'd5));
      send_particle(make_particle(1'b1, 8'h40, '0, '0, '0, NORM_MIN, NORM_MIN, '0,
                                  32'h0000_0000, 8'd6));
   endtask

   task automatic test_random_traffic(int count);
      for (int i = 0; i < count; i++)
         send_particle(rand_particle());
   endtask

   // Response side: random stall bursts while enabled, otherwise always ready.
   always begin
      @(posedge clock);
      if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // Compare each accepted response with the oldest outstanding child.
   function automatic int field_mismatch(string name, logic [31:0] expected_v,
                                         logic [31:0] actual_v);
      if (expected_v === actual_v)
         return 0;
      $error("%s: expected %h, got %h", name, expected_v, actual_v);
      return 1;
   endfunction

   always @(posedge clock) begin : response_check
      child_type c;
      int        errs;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_children.size() == 0) begin
            $error("response with no child outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            c = pending_children.pop_front();
            errs = 0;
            errs += field_mismatch("out_index", c.out_index, rsp_tdata[31:0]);
            errs += field_mismatch("new_x", c.new_x, rsp_tdata[63:32]);
            errs += field_mismatch("new_y", c.new_y, rsp_tdata[95:64]);
            errs += field_mismatch("new_z", c.new_z, rsp_tdata[127:96]);
            errs += field_mismatch("new_nx", {16'd0, c.new_nx}, {16'd0, rsp_tdata[143:128]});
            errs += field_mismatch("new_ny", {16'd0, c.new_ny}, {16'd0, rsp_tdata[159:144]});
            errs += field_mismatch("new_nz", {16'd0, c.new_nz}, {16'd0, rsp_tdata[175:160]});
            errs += field_mismatch("new_spacing", c.new_spacing, rsp_tdata[207:176]);
            errs += field_mismatch("new_level", {24'd0, c.new_level},
                                   {24'd0, rsp_tdata[215:208]});
            errs += field_mismatch("new_kind", {24'd0, c.new_kind}, {24'd0, rsp_tuser});
            errs += field_mismatch("last", {31'd0, c.last}, {31'd0, rsp_tlast});
            if (errs != 0)
               fail_count++;
         end
      end
   end

   // Test sequence.
   initial begin
      fail_count     = 0;
      next_out_index = '0;
      req_gaps_on    = 1'b0;
      rsp_stalls_on  = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_unsplit_copy();
      test_interior_split();
      test_boundary_split();
      wait_for_drain();

      test_random_traffic(200);
      wait_for_drain();
      test_random_traffic(200);

      // Final stretch at full rate on both sides.
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_traffic(100);
      wait_for_drain();

      if (fail_count == 0) begin
         $display("particle_split_refiner_2d_core_tb: PASS");
      end else begin
         $display("particle_split_refiner_2d_core_tb: FAIL");
      end
      $finish;
   end

endmodule
